// ===== src/bba_pkg.sv =====
// Shared types and constants of the bitmap boundary allocator.
package bba_pkg;

   // Field widths of the request and response channels.
   localparam int FUNC_W   = 1;
   localparam int SIZE_W   = 12;
   localparam int UNIT_W   = 12;
   localparam int START_W  = 11;
   localparam int STATUS_W = 2;

   // Mark memory geometry: one row holds the marks of 32 units.
   localparam int ROW_BITS  = 32;
   localparam int ROW_SHIFT = 5;
   localparam int POS_W     = 5;

   // The pool size is always a whole number of groups of eight units.
   localparam int GROUP    = 8;
   localparam int MAX_POOL = ((2 ** UNIT_W) - 1) / GROUP * GROUP;

   // Pool size register value after reset.
   localparam logic [UNIT_W-1:0] RESET_UNITS = 12'd2048;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Scan state carried from one mark row to the next.
   typedef struct packed {
      logic              enclosed;
      logic [UNIT_W-1:0] run;
      logic [UNIT_W-1:0] run_start;
   } fit_carry_type;

   // Outcome of evaluating one mark row during an allocate scan.
   typedef struct packed {
      logic              found;
      logic [UNIT_W-1:0] first;
      logic [UNIT_W-1:0] last;
      fit_carry_type     carry;
   } fit_result_type;

endpackage

// ===== src/bba_req_if.sv =====
// Request channel of the bitmap boundary allocator.
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [SIZE_W-1:0] request_size;
   logic [UNIT_W-1:0] region_start;

   modport source (output valid, func, request_size, region_start, input ready);
   modport sink (input valid, func, request_size, region_start, output ready);
endinterface

// ===== src/bba_rsp_if.sv =====
// Response channel of the bitmap boundary allocator.
interface bba_rsp_if;
   import bba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [START_W-1:0]  start_unit;
   logic [UNIT_W-1:0]   free_units;

   modport source (output valid, status, start_unit, free_units, input ready);
   modport sink (input valid, status, start_unit, free_units, output ready);
endinterface

// ===== src/bba_mark_ram.sv =====
// Mark memory: one write port and one registered read port, 32 marks per row.
module bba_mark_ram #(
   parameter int ROWS  = 64,
   parameter int ROW_W = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ROW_W-1:0]              wr_addr,
   input  logic [bba_pkg::ROW_BITS-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [ROW_W-1:0]              rd_addr,
   output logic [bba_pkg::ROW_BITS-1:0]  rd_data
);
   import bba_pkg::*;

   logic [ROW_BITS-1:0] marks_mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         marks_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= marks_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/bba_row_fit.sv =====
// First-fit evaluation of one 32-mark row, continuing the scan state of earlier rows.
module bba_row_fit (
   input  logic [bba_pkg::ROW_BITS-1:0] marks,
   input  logic [bba_pkg::UNIT_W-1:0]   row_base,
   input  logic [bba_pkg::UNIT_W-1:0]   pool_units,
   input  logic [bba_pkg::SIZE_W-1:0]   need,
   input  bba_pkg::fit_carry_type       carry_in,
   output bba_pkg::fit_result_type      result
);
   import bba_pkg::*;

   logic [UNIT_W:0]      span;
   logic [ROW_BITS-1:0]  live;
   logic [ROW_BITS-1:0]  marks_live;
   logic [ROW_BITS-1:0]  open_unit;
   logic [ROW_BITS-1:0]  dbl [POS_W+1];
   logic [ROW_BITS-1:0]  window;
   logic [POS_W:0]       lead_ones;
   logic [POS_W:0]       need_low;
   logic [POS_W-1:0]     last_zero;
   logic [POS_W-1:0]     pos_a;
   logic [POS_W-1:0]     pos_b;
   logic [UNIT_W:0]      reach;
   logic [UNIT_W-1:0]    run_start_a;
   logic                 all_open;
   logic                 a_hit;
   logic                 b_hit;

   always_comb begin
      // Units at or beyond the pool end take no part in the scan.
      span = {1'b0, pool_units} - {1'b0, row_base};
      for (int r = 0; r < ROW_BITS; r++) begin
         live[r] = span > (UNIT_W+1)'(r);
      end
      marks_live = marks & live;

      // A unit is open when it is unmarked and not between a pair of marks.
      for (int r = 0; r < ROW_BITS; r++) begin
         open_unit[r] = live[r] & ~marks_live[r] &
            ~(carry_in.enclosed ^ (^(marks_live & ((ROW_BITS'(1) << r) - ROW_BITS'(1)))));
      end
      all_open = &open_unit;

      // Open units from bit 0 up, and the last closed unit of the row.
      lead_ones = (POS_W+1)'(ROW_BITS);
      for (int r = ROW_BITS - 1; r >= 0; r--) begin
         if (!open_unit[r]) begin
            lead_ones = (POS_W+1)'(r);
         end
      end
      last_zero = '0;
      for (int r = 0; r < ROW_BITS; r++) begin
         if (!open_unit[r]) begin
            last_zero = POS_W'(r);
         end
      end

      // Case A: the run carried in from earlier rows reaches the size here.
      reach       = {1'b0, carry_in.run} + (UNIT_W+1)'(lead_ones);
      a_hit       = reach >= {1'b0, need};
      pos_a       = POS_W'(need - carry_in.run - SIZE_W'(1));
      run_start_a = (carry_in.run == '0) ? row_base : carry_in.run_start;

      // Case B: a window of the requested size lies wholly in this row.
      // Bit i of dbl[k] is set when the 2**k units ending at i are all open.
      dbl[0] = open_unit;
      for (int k = 1; k <= POS_W; k++) begin
         dbl[k] = dbl[k-1] & (dbl[k-1] << (1 << (k - 1)));
      end
      need_low = need[POS_W:0];
      window   = '1;
      for (int k = 0; k <= POS_W; k++) begin
         if (need_low[k]) begin
            window = window & (dbl[k] << (need_low & (POS_W+1)'((1 << k) - 1)));
         end
      end
      b_hit = (need <= SIZE_W'(ROW_BITS)) && (|window);
      pos_b = '0;
      for (int r = ROW_BITS - 1; r >= 0; r--) begin
         if (window[r]) begin
            pos_b = POS_W'(r);
         end
      end

      // A carried run always ends no later than a window found in the row.
      result.found = a_hit | b_hit;
      if (a_hit) begin
         result.first = run_start_a;
         result.last  = row_base + UNIT_W'(pos_a);
      end else begin
         result.last  = row_base + UNIT_W'(pos_b);
         result.first = row_base + UNIT_W'(pos_b) - need + UNIT_W'(1);
      end

      // Scan state handed to the next row.
      result.carry.enclosed = carry_in.enclosed ^ (^marks_live);
      if (all_open) begin
         result.carry.run       = carry_in.run + UNIT_W'(ROW_BITS);
         result.carry.run_start = run_start_a;
      end else begin
         result.carry.run       = UNIT_W'(POS_W'(ROW_BITS - 1) - last_zero);
         result.carry.run_start = row_base + UNIT_W'(last_zero) + UNIT_W'(1);
      end
   end
endmodule

// ===== src/bitmap_boundary_allocator.sv =====
// Bitmap boundary allocator: first-fit regions over a mark memory read 32 marks per row a cycle.
// An allocate scans rows, then writes the marks, one more row write if the region crosses a row;
// a free scans rows, then sums; a rejected request skips the scan. A full 2048-unit scan is 64 rows.
// One request is in work at a time; the next is taken once the result sits in the output register.
// After reset and after each pool size write a clearing pass of one row per cycle zeroes the
// mark memory; requests are held off until it ends.
module bitmap_boundary_allocator #(
   parameter int POOL_UNITS = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   bba_req_if.sink                       req_bus,
   bba_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [bba_pkg::UNIT_W-1:0]    csr_write_data
);
   import bba_pkg::*;

   localparam int POOL_CAP_RAW = (POOL_UNITS / GROUP) * GROUP;
   localparam int POOL_CAP     = (POOL_CAP_RAW > MAX_POOL) ? MAX_POOL : POOL_CAP_RAW;
   localparam int ROWS         = (POOL_CAP + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [UNIT_W-1:0] CAP_UNITS    = UNIT_W'(POOL_CAP);
   localparam logic [ROW_W-1:0]  LAST_MEM_ROW = ROW_W'(ROWS - 1);

   // Controller states.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_START   = 4'd2;
   localparam logic [3:0] ST_A_SCAN  = 4'd3;
   localparam logic [3:0] ST_A_MARK  = 4'd4;
   localparam logic [3:0] ST_A_MARK2 = 4'd5;
   localparam logic [3:0] ST_F_SCAN  = 4'd6;
   localparam logic [3:0] ST_F_SUM   = 4'd7;
   localparam logic [3:0] ST_RESP    = 4'd8;

   function automatic logic [ROW_W-1:0] row_of(input logic [UNIT_W-1:0] unit_idx);
      logic [UNIT_W-ROW_SHIFT-1:0] row_full;
      row_full = unit_idx[UNIT_W-1:ROW_SHIFT];
      return row_full[ROW_W-1:0];
   endfunction

   function automatic logic [UNIT_W-1:0] pool_of(input logic [UNIT_W-1:0] units);
      logic [UNIT_W-1:0] rounded;
      rounded = units & ~UNIT_W'(GROUP - 1);
      return (rounded > CAP_UNITS) ? CAP_UNITS : rounded;
   endfunction

   // Control registers.
   logic [3:0]          state_ff, state_in;
   logic [UNIT_W-1:0]   units_ff, units_in;
   logic [UNIT_W-1:0]   free_ff, free_in;
   logic [ROW_W-1:0]    cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request and work registers.
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [SIZE_W-1:0]   need_ff, need_in;
   logic [UNIT_W-1:0]   where_ff, where_in;
   fit_carry_type       carry_ff, carry_in;
   logic [UNIT_W-1:0]   first_ff, first_in;
   logic [UNIT_W-1:0]   last_ff, last_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                lead_row_ff, lead_row_in;
   logic [UNIT_W-1:0]   end_ff, end_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [START_W-1:0]  res_start_ff, res_start_in;

   // Output register.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [UNIT_W-1:0]   rsp_free_ff, rsp_free_in;

   // Memory port signals.
   logic                mem_we;
   logic [ROW_W-1:0]    mem_waddr;
   logic [ROW_BITS-1:0] mem_wdata;
   logic                mem_re;
   logic [ROW_W-1:0]    mem_raddr;
   logic [ROW_BITS-1:0] mem_rdata;

   // Derived values.
   logic [UNIT_W-1:0]   pool_units;
   logic [ROW_W-1:0]    last_row;
   logic [UNIT_W-1:0]   row_base;
   logic [SIZE_W-1:0]   raised_size;
   fit_result_type      fit;
   logic [POS_W-1:0]    where_pos;
   logic [ROW_BITS-1:0] above;
   logic [ROW_BITS-1:0] cand;
   logic                cand_hit;
   logic [POS_W-1:0]    hit_pos;
   logic [ROW_BITS-1:0] clr_mask;
   logic [UNIT_W-1:0]   region_len;
   logic [UNIT_W:0]     free_sum;
   logic                same_row;
   logic [ROW_BITS-1:0] last_bit;
   logic [ROW_BITS-1:0] first_bit;

   bba_mark_ram #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bba_row_fit u_row_fit (
      .marks      (mem_rdata),
      .row_base   (row_base),
      .pool_units (pool_units),
      .need       (need_ff),
      .carry_in   (carry_ff),
      .result     (fit)
   );

   // Pool geometry and row addressing.
   assign pool_units  = pool_of(units_ff);
   assign last_row    = row_of(pool_units - UNIT_W'(1));
   assign row_base    = UNIT_W'(cur_ff) << ROW_SHIFT;
   assign raised_size = (need_ff == SIZE_W'(1)) ? SIZE_W'(2) : need_ff;

   // Free scan: the next mark after the region start, clearing both marks.
   always_comb begin
      where_pos = where_ff[POS_W-1:0];
      above     = lead_row_ff ? ((ROW_BITS'('1) << where_pos) << 1) : ROW_BITS'('1);
      cand      = mem_rdata & above;
      cand_hit  = |cand;
      hit_pos   = '0;
      for (int r = ROW_BITS - 1; r >= 0; r--) begin
         if (cand[r]) begin
            hit_pos = POS_W'(r);
         end
      end
      clr_mask = (lead_row_ff ? (ROW_BITS'(1) << where_pos) : '0) |
                 (cand_hit ? (ROW_BITS'(1) << hit_pos) : '0);
   end

   // Region length and saturating free count update.
   assign region_len = end_ff - where_ff + UNIT_W'(1);
   assign free_sum   = {1'b0, free_ff} + {1'b0, region_len};

   // Boundary mark bits of a new region.
   assign same_row  = row_of(first_ff) == row_of(last_ff);
   assign last_bit  = ROW_BITS'(1) << last_ff[POS_W-1:0];
   assign first_bit = ROW_BITS'(1) << first_ff[POS_W-1:0];

   assign req_bus.ready = (state_ff == ST_IDLE);

   // Controller.
   always_comb begin
      state_in      = state_ff;
      units_in      = units_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      func_in       = func_ff;
      need_in       = need_ff;
      where_in      = where_ff;
      carry_in      = carry_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      row_in        = row_ff;
      lead_row_in   = lead_row_ff;
      end_in        = end_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = cur_ff + ROW_W'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (cur_ff == LAST_MEM_ROW) begin
               state_in = ST_IDLE;
            end else begin
               cur_in = cur_ff + ROW_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               func_in  = req_bus.func;
               need_in  = req_bus.request_size;
               where_in = req_bus.region_start;
               state_in = ST_START;
            end
         end
         ST_START: begin
            res_status_in = STATUS_OK;
            res_start_in  = '0;
            if (func_ff == FUNC_ALLOC) begin
               need_in = raised_size;
               if (raised_size == '0 || raised_size > free_ff) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = ST_RESP;
               end else begin
                  mem_re             = 1'b1;
                  mem_raddr          = '0;
                  cur_in             = '0;
                  carry_in.enclosed  = 1'b0;
                  carry_in.run       = '0;
                  carry_in.run_start = '0;
                  state_in           = ST_A_SCAN;
               end
            end else begin
               if (where_ff >= pool_units) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_RESP;
               end else begin
                  mem_re      = 1'b1;
                  mem_raddr   = row_of(where_ff);
                  cur_in      = row_of(where_ff);
                  lead_row_in = 1'b1;
                  state_in    = ST_F_SCAN;
               end
            end
         end
         ST_A_SCAN: begin
            mem_re = (cur_ff != last_row);
            if (fit.found) begin
               first_in = fit.first;
               last_in  = fit.last;
               row_in   = mem_rdata;
               state_in = ST_A_MARK;
            end else if (cur_ff == last_row) begin
               res_status_in = STATUS_FAIL;
               state_in      = ST_RESP;
            end else begin
               carry_in = fit.carry;
               cur_in   = cur_ff + ROW_W'(1);
            end
         end
         ST_A_MARK: begin
            // Set the end mark, and the start mark too when it is in the same row.
            mem_we    = 1'b1;
            mem_waddr = row_of(last_ff);
            mem_wdata = row_ff | last_bit | (same_row ? first_bit : '0);
            if (same_row) begin
               free_in      = free_ff - need_ff;
               res_start_in = first_ff[START_W-1:0];
               state_in     = ST_RESP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = row_of(first_ff);
               state_in  = ST_A_MARK2;
            end
         end
         ST_A_MARK2: begin
            mem_we       = 1'b1;
            mem_waddr    = row_of(first_ff);
            mem_wdata    = mem_rdata | first_bit;
            free_in      = free_ff - need_ff;
            res_start_in = first_ff[START_W-1:0];
            state_in     = ST_RESP;
         end
         ST_F_SCAN: begin
            mem_we      = lead_row_ff | cand_hit;
            mem_wdata   = mem_rdata & ~clr_mask;
            mem_re      = (cur_ff != last_row);
            lead_row_in = 1'b0;
            if (cand_hit) begin
               end_in   = row_base + UNIT_W'(hit_pos);
               state_in = ST_F_SUM;
            end else if (cur_ff == last_row) begin
               end_in   = pool_units - UNIT_W'(1);
               state_in = ST_F_SUM;
            end else begin
               cur_in = cur_ff + ROW_W'(1);
            end
         end
         ST_F_SUM: begin
            free_in  = (free_sum > {1'b0, pool_units}) ? pool_units : free_sum[UNIT_W-1:0];
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_free_in   = free_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A pool size write starts over with an empty pool.
      if (csr_write_enable) begin
         units_in = csr_write_data;
         free_in  = pool_of(csr_write_data);
         cur_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         units_ff     <= RESET_UNITS;
         free_ff      <= pool_of(RESET_UNITS);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lead_row_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         units_ff     <= units_in;
         free_ff      <= free_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         lead_row_ff  <= lead_row_in;
      end
   end

   // Payload and work registers.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      need_ff       <= need_in;
      where_ff      <= where_in;
      carry_ff      <= carry_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      row_ff        <= row_in;
      end_ff        <= end_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.start_unit = rsp_start_ff;
   assign rsp_bus.free_units = rsp_free_ff;

   // The mark memory is never written and read at the same row in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("mark memory read and write collide on one row");

   // The free count never exceeds the pool size.
   assert property (@(posedge clock) disable iff (reset)
      free_ff <= pool_units)
      else $error("free count exceeds pool size");

   // A fit found in a row spans exactly the requested number of units.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_SCAN && fit.found) |-> (fit.last - fit.first + UNIT_W'(1) == need_ff))
      else $error("fit length differs from request size");

   // A fit found in a row ends inside that row.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_SCAN && fit.found) |-> (row_of(fit.last) == cur_ff))
      else $error("fit ends outside the scanned row");
endmodule
